[sv/bihc_pkg.sv]
// ----------------------------------------------------------------------------
// bihc_pkg
// types, codes and header layout constants for the boot image header checker
// ----------------------------------------------------------------------------
package bihc_pkg;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_ACCEPTED = 3'd1,
    ST_BAD_SIG1 = 3'd2,
    ST_BAD_SIG2 = 3'd3,
    ST_PAD      = 3'd4,
    ST_VERSION  = 3'd5,
    ST_SHORT    = 3'd6
  } status_t;

  localparam int POS_W = 10;
  typedef logic [POS_W-1:0] pos_t;

  // header layout, byte offsets
  localparam pos_t POS_VERSION  = 10'd4;
  localparam pos_t POS_LOAD     = 10'd8;
  localparam pos_t POS_BRANCH   = 10'd12;
  localparam pos_t POS_SIZE     = 10'd16;
  localparam pos_t POS_SIG2     = 10'd24;
  localparam pos_t POS_PAD      = 10'd28;
  localparam pos_t POS_HDR_LAST = 10'd511;
  localparam pos_t HDR_LEN      = 10'd512;

  localparam logic [7:0] SIGNATURE [4] = '{8'h58, 8'h69, 8'h6E, 8'h75};

  typedef struct packed {
    logic sig1;
    logic sig2;
    logic pad;
    logic ver;
  } failures_t;

  typedef struct packed {
    pos_t        pos;
    failures_t   fail;
    status_t     outcome;
    logic [31:0] wptr;
    logic [31:0] branch;
  } state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_image;
    logic       end_of_block;
  } in_word_t;

  typedef struct packed {
    logic        write_enable;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    status_t     header_status;
    logic [31:0] jump_address;
  } out_word_t;

  localparam state_t STATE_RESET = '{
    pos: '0, fail: '0, outcome: ST_PENDING, wptr: '0, branch: '0
  };

endpackage

[sv/bihc_in_if.sv]
// ----------------------------------------------------------------------------
// bihc_in_if
// image byte channel: valid/ready handshake with byte and framing marks
// ----------------------------------------------------------------------------
interface bihc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_image;
  logic       end_of_block;

  modport source (output valid, output data_byte, output start_of_image,
                  output end_of_block, input ready);
  modport sink   (input valid, input data_byte, input start_of_image,
                  input end_of_block, output ready);
endinterface

[sv/bihc_out_if.sv]
// ----------------------------------------------------------------------------
// bihc_out_if
// result channel: memory write request and header status per byte
// ----------------------------------------------------------------------------
interface bihc_out_if;
  logic        valid;
  logic        ready;
  logic        write_enable;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic [2:0]  header_status;
  logic [31:0] jump_address;

  modport source (output valid, output write_enable, output write_address,
                  output write_data, output header_status,
                  output jump_address, input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input write_data, input header_status,
                  input jump_address, output ready);
endinterface

[sv/bihc_step.sv]
// ----------------------------------------------------------------------------
// bihc_step
// per-byte header parse, check and payload address logic
// ----------------------------------------------------------------------------
module bihc_step
  import bihc_pkg::*;
(
  input  state_t    cur,
  input  in_word_t  word,
  output state_t    state_next,
  output out_word_t res
);

  state_t s;
  pos_t   p;

  always_comb begin
    s          = word.start_of_image ? STATE_RESET : cur;
    p          = s.pos;
    state_next = s;
    res        = '0;

    if (s.outcome == ST_PENDING) begin
      if (p < POS_VERSION) begin
        if (word.data_byte != SIGNATURE[p[1:0]]) begin
          state_next.fail.sig1 = 1'b1;
        end
      end else if (p < POS_LOAD) begin
        if (word.data_byte != 8'd0) begin
          state_next.fail.ver = 1'b1;
        end
      end else if (p < POS_BRANCH) begin
        state_next.wptr[{p[1:0], 3'b000} +: 8] = word.data_byte;
      end else if (p < POS_SIZE) begin
        state_next.branch[{p[1:0], 3'b000} +: 8] = word.data_byte;
      end else if (p < POS_SIG2) begin
        state_next.pos = p;
      end else if (p < POS_PAD) begin
        if (word.data_byte != SIGNATURE[p[1:0]]) begin
          state_next.fail.sig2 = 1'b1;
        end
      end else begin
        if (word.data_byte != 8'd0) begin
          state_next.fail.pad = 1'b1;
        end
      end
      state_next.pos = p + 10'd1;

      if (p == POS_HDR_LAST) begin
        if (state_next.fail.sig1) begin
          state_next.outcome = ST_BAD_SIG1;
        end else if (state_next.fail.sig2) begin
          state_next.outcome = ST_BAD_SIG2;
        end else if (state_next.fail.pad) begin
          state_next.outcome = ST_PAD;
        end else if (state_next.fail.ver) begin
          state_next.outcome = ST_VERSION;
        end else begin
          state_next.outcome = ST_ACCEPTED;
        end
      end else if (word.end_of_block) begin
        state_next.outcome = ST_SHORT;
      end
    end else if (s.outcome == ST_ACCEPTED) begin
      res.write_enable  = 1'b1;
      res.write_address = s.wptr;
      res.write_data    = word.data_byte;
      state_next.wptr   = s.wptr + 32'd1;
    end

    res.header_status = state_next.outcome;
    res.jump_address  = (state_next.outcome == ST_ACCEPTED) ? state_next.branch : 32'd0;
  end

endmodule

[sv/boot_image_header_checker.sv]
// ----------------------------------------------------------------------------
// boot_image_header_checker
// parses and checks a 512-byte boot image header, then issues payload writes
// ----------------------------------------------------------------------------
// image: one byte per word, with start_of_image restarting the header parse
//   and end_of_block marking the end of a transfer block.
// result: one word for every image word, carrying the memory write request
//   (write_enable, write_address, write_data), the header status and the
//   branch address once the header is accepted.
// throughput: one byte per cycle while result.ready is high; a word passes
//   an input register and the header/address logic into a result register,
//   and a result is registered once the result register is free.
// stall: when result.ready is low a valid result is held, the input
//   register takes a word only while empty, and image.ready is low while full.
// reset: rst clears both valid flags and the parse state; the first byte
//   after reset is taken as header byte 0.
// ----------------------------------------------------------------------------
module boot_image_header_checker
  import bihc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  bihc_in_if.sink      image,
  bihc_out_if.source   result
);

  in_word_t  in_reg;
  logic      in_reg_valid;
  out_word_t out_reg;
  logic      out_valid;
  state_t    state;
  state_t    state_next;
  out_word_t res_next;
  logic      advance;

  assign advance     = in_reg_valid && (!out_valid || result.ready);
  assign image.ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (image.ready) begin
      in_reg_valid <= image.valid;
    end
    if (image.valid && image.ready) begin
      in_reg.data_byte      <= image.data_byte;
      in_reg.start_of_image <= image.start_of_image;
      in_reg.end_of_block   <= image.end_of_block;
    end
  end

  bihc_step u_step (
    .cur        (state),
    .word       (in_reg),
    .state_next (state_next),
    .res        (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= STATE_RESET;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        state     <= state_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      out_reg <= res_next;
    end
  end

  assign result.valid         = out_valid;
  assign result.write_enable  = out_reg.write_enable;
  assign result.write_address = out_reg.write_address;
  assign result.write_data    = out_reg.write_data;
  assign result.header_status = out_reg.header_status;
  assign result.jump_address  = out_reg.jump_address;

  a_write_needs_accept: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_reg.write_enable |-> out_reg.header_status == ST_ACCEPTED)
    else $error("payload write without accepted header");

  a_accept_at_full_header: assert property (@(posedge clk) disable iff (rst)
    state.outcome == ST_ACCEPTED |-> state.pos == HDR_LEN)
    else $error("header accepted before all header bytes were seen");

  a_pending_in_header: assert property (@(posedge clk) disable iff (rst)
    state.outcome == ST_PENDING |-> state.pos < HDR_LEN)
    else $error("header complete but outcome still pending");

  a_held_word_kept: assert property (@(posedge clk) disable iff (rst)
    in_reg_valid && !advance |=> in_reg_valid && $stable(in_reg))
    else $error("registered byte lost while result stalled");

endmodule
